/* rtl/frame_rms_meter_top_defines.svh */
// ----------------------------------------------------------------------------
// frame_rms_meter_top_defines
// Assertion macros for the frame RMS meter. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef FRAME_RMS_METER_TOP_DEFINES_SVH
`define FRAME_RMS_METER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define FRM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("frame rms meter assertion failed");
// checked at every edge, reset included
`define FRM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("frame rms meter assertion failed");
`else
`define FRM_ASSERT(label, clk, rst, prop)
`define FRM_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* rtl/frm_pkg.sv */
// ----------------------------------------------------------------------------
// frm_pkg
// Types and fixed widths shared by the frame RMS meter.
// ----------------------------------------------------------------------------
package frm_pkg;

  localparam int SAMPLE_W = 16;  // pcm sample
  localparam int MAG_W    = 16;  // sample magnitude, 0..32768
  localparam int PROD_W   = 32;  // one square
  localparam int ROOT_W   = 16;  // rms level
  localparam int RAD_W    = 32;  // square root operand
  localparam int SREM_W   = 18;  // square root remainder

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;
  } frm_in_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rms_level;
    logic              frame_overflow;
  } frm_out_t;

  typedef enum logic [2:0] {
    FRM_IDLE,
    FRM_SQUARE,
    FRM_ACCUM,
    FRM_DIVIDE,
    FRM_SQRT,
    FRM_DONE
  } frm_state_t;

endpackage

/* rtl/frame_rms_meter_top.sv */
// ----------------------------------------------------------------------------
// frame_rms_meter_top
// Frame RMS level meter: sums squared samples over a frame, then gives
// floor(sqrt(floor(sum / count))) with 32768 as full scale.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  sample    sample_valid / sample_ready  sample_item (sample, frame_end)
//  level     level_valid / level_ready    level_item (rms_level, frame_overflow)
//
//  each sample is accepted in IDLE, squared bit-serially in SQUARE, then added
//  into the frame sum in ACCUM; a sample past the frame limit is only accepted.
//  a frame's last sample then goes through restoring division in DIVIDE (one
//  quotient bit a cycle) and square root in SQRT (one root bit a cycle), then
//  loads the output register in DONE. a new sample is taken only in IDLE.
//  reset clears the frame state and empties the output register.
//  samples are taken while a result still waits in the output register; only
//  the final load stalls on level_ready.
// ----------------------------------------------------------------------------
`include "frame_rms_meter_top_defines.svh"

module frame_rms_meter_top #(
  parameter int MAX_FRAME_SAMPLES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  frm_pkg::frm_in_t  sample_item,
  output logic              level_valid,
  input  logic              level_ready,
  output frm_pkg::frm_out_t level_item
);

  import frm_pkg::*;

  localparam int CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W  = PROD_W - 2 + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);

  frm_state_t state, state_next;

  // frame accumulation
  logic [SUM_W-1:0]  square_sum;
  logic [CNT_W-1:0]  sample_count;
  logic              overflow_seen;
  logic              last_pending;

  // bit-serial square
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  mcand;
  logic [MAG_W:0]    prod_add;
  logic [PROD_W-1:0] prod_next;

  // restoring divider
  logic [SUM_W-1:0]  quot;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  divisor;
  logic [CNT_W:0]    div_shift;
  logic              div_ge;
  logic [SUM_W-1:0]  quot_next;
  logic              ovf_res;

  // square root
  logic [RAD_W-1:0]  rad;
  logic [SREM_W-1:0] srem;
  logic [ROOT_W-1:0] root;
  logic [SREM_W+1:0] sqrt_shift;
  logic [SREM_W+1:0] sqrt_trial;
  logic              sqrt_ge;
  logic [ROOT_W-1:0] root_next;

  logic [STEP_W-1:0] step;
  logic              step_last;
  logic              accept;
  logic              frame_full;
  logic [MAG_W-1:0]  mag;
  logic [SUM_W-1:0]  sum_next;
  logic              out_load;

  assign accept     = sample_valid && sample_ready;
  assign frame_full = (sample_count == CNT_W'(MAX_FRAME_SAMPLES));
  assign step_last  = (step == '0);
  assign mag        = sample_item.sample[SAMPLE_W-1] ?
                      MAG_W'(~sample_item.sample + 1'b1) : MAG_W'(sample_item.sample);

  // one multiplier bit per cycle, product shifts right
  assign prod_add  = {1'b0, prod[PROD_W-1 -: MAG_W]} + (prod[0] ? {1'b0, mcand} : '0);
  assign prod_next = {prod_add, prod[PROD_W-MAG_W-1:1]};
  assign sum_next  = square_sum + SUM_W'(prod);

  // one quotient bit per cycle
  assign div_shift = {rem, quot[SUM_W-1]};
  assign div_ge    = (div_shift >= {1'b0, divisor});
  assign quot_next = {quot[SUM_W-2:0], div_ge};

  // one root bit per cycle
  assign sqrt_shift = {srem, rad[RAD_W-1 -: 2]};
  assign sqrt_trial = {2'b00, root, 2'b01};
  assign sqrt_ge    = (sqrt_shift >= sqrt_trial);
  assign root_next  = {root[ROOT_W-2:0], sqrt_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FRM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    out_load     = 1'b0;
    case (state)
      FRM_IDLE: begin
        sample_ready = !rst;
        if (accept) begin
          if (!frame_full) begin
            state_next = FRM_SQUARE;
          end else if (sample_item.frame_end) begin
            state_next = FRM_DIVIDE;
          end
        end
      end
      FRM_SQUARE: begin
        if (step_last) begin
          state_next = FRM_ACCUM;
        end
      end
      FRM_ACCUM: begin
        state_next = last_pending ? FRM_DIVIDE : FRM_IDLE;
      end
      FRM_DIVIDE: begin
        if (step_last) begin
          state_next = FRM_SQRT;
        end
      end
      FRM_SQRT: begin
        if (step_last) begin
          state_next = FRM_DONE;
        end
      end
      FRM_DONE: begin
        if (!level_valid || level_ready) begin
          out_load   = 1'b1;
          state_next = FRM_IDLE;
        end
      end
      default: begin
        state_next = FRM_IDLE;
      end
    endcase
  end

  // frame state and control
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum    <= '0;
      sample_count  <= '0;
      overflow_seen <= 1'b0;
      last_pending  <= 1'b0;
      level_valid   <= 1'b0;
    end else begin
      if (accept) begin
        last_pending <= sample_item.frame_end;
        if (!frame_full) begin
          sample_count <= sample_count + 1'b1;
        end else if (sample_item.frame_end) begin
          // closing sample of a full frame: hand the sum over now
          square_sum    <= '0;
          sample_count  <= '0;
          overflow_seen <= 1'b0;
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (state == FRM_ACCUM) begin
        if (last_pending) begin
          square_sum    <= '0;
          sample_count  <= '0;
          overflow_seen <= 1'b0;
        end else begin
          square_sum <= sum_next;
        end
      end
      if (out_load) begin
        level_valid <= 1'b1;
      end else if (level_ready) begin
        level_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      if (frame_full && sample_item.frame_end) begin
        quot    <= square_sum;
        rem     <= '0;
        divisor <= sample_count;
        ovf_res <= 1'b1;
        step    <= STEP_W'(SUM_W - 1);
      end else begin
        prod  <= PROD_W'(mag);
        mcand <= mag;
        step  <= STEP_W'(MAG_W - 1);
      end
    end
    case (state)
      FRM_SQUARE: begin
        prod <= prod_next;
        step <= step - 1'b1;
      end
      FRM_ACCUM: begin
        quot    <= sum_next;
        rem     <= '0;
        divisor <= sample_count;
        ovf_res <= overflow_seen;
        step    <= STEP_W'(SUM_W - 1);
      end
      FRM_DIVIDE: begin
        quot <= quot_next;
        rem  <= div_ge ? CNT_W'(div_shift - {1'b0, divisor}) : CNT_W'(div_shift);
        if (step_last) begin
          // mean of squares stays below 2^31
          rad  <= RAD_W'(quot_next);
          srem <= '0;
          root <= '0;
          step <= STEP_W'(ROOT_W - 1);
        end else begin
          step <= step - 1'b1;
        end
      end
      FRM_SQRT: begin
        rad  <= rad << 2;
        srem <= sqrt_ge ? SREM_W'(sqrt_shift - sqrt_trial) : SREM_W'(sqrt_shift);
        root <= root_next;
        step <= step - 1'b1;
      end
      FRM_DONE: begin
        if (out_load) begin
          level_item.rms_level      <= root;
          level_item.frame_overflow <= ovf_res;
        end
      end
      default: begin
      end
    endcase
  end

  `FRM_ASSERT(a_count_bound, clk, rst, sample_count <= CNT_W'(MAX_FRAME_SAMPLES))
  `FRM_ASSERT(a_rem_below_divisor, clk, rst, (state == FRM_DIVIDE) |-> (rem < divisor))
  `FRM_ASSERT(a_last_leaves_idle, clk, rst, (accept && sample_item.frame_end) |=> (state != FRM_IDLE))
  `FRM_ASSERT(a_level_range, clk, rst, level_valid |-> (level_item.rms_level <= 16'd32768))
  `FRM_ASSERT(a_load_from_done, clk, rst, (level_valid && !$past(level_valid)) |-> ($past(state) == FRM_DONE))
  `FRM_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !level_valid)

endmodule
